[rtl/dkm_pkg.sv]
// ----------------------------------------------------------------------------
// dkm_pkg: shared types and constants of the demag kernel multiply block
// Word layouts of both channels, the kernel store word, configuration
// register indexes and the index-stage result.
// ----------------------------------------------------------------------------
`default_nettype none

package dkm_pkg;

	// Fixed point format of every data word (Q16.16)
	localparam int VALUE_WIDTH   = 32;
	localparam int FRACTION_BITS = 16;

	localparam int KERNEL_DEPTH_DEFAULT = 4096;

	localparam int IDX_W      = 7;
	localparam int PSTRIDE_W  = 13;
	// x + y*row_stride + z*plane_stride, unbounded sum of the index stage
	localparam int ADDR_SUM_W = 21;
	localparam int VEC_WORDS  = 6;

	localparam int CFG_INDEX_W = 3;
	localparam int CFG_DATA_W  = 13;

	localparam logic [CFG_INDEX_W-1:0] REG_MODE_THREE_D = 3'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_HALF_Y       = 3'd1;
	localparam logic [CFG_INDEX_W-1:0] REG_HALF_Z       = 3'd2;
	localparam logic [CFG_INDEX_W-1:0] REG_ROW_STRIDE   = 3'd3;
	localparam logic [CFG_INDEX_W-1:0] REG_PLANE_STRIDE = 3'd4;

	localparam logic OP_MULTIPLY = 1'b0;
	localparam logic OP_LOAD     = 1'b1;

	typedef struct packed {
		logic                          opcode;
		logic [IDX_W-1:0]              x_index;
		logic [IDX_W-1:0]              y_index;
		logic [IDX_W-1:0]              z_index;
		logic signed [VALUE_WIDTH-1:0] word_a;
		logic signed [VALUE_WIDTH-1:0] word_b;
		logic signed [VALUE_WIDTH-1:0] word_c;
		logic signed [VALUE_WIDTH-1:0] word_d;
		logic signed [VALUE_WIDTH-1:0] word_e;
		logic signed [VALUE_WIDTH-1:0] word_f;
	} dkm_cmd_t;

	typedef struct packed {
		logic signed [VALUE_WIDTH-1:0] out_x_re;
		logic signed [VALUE_WIDTH-1:0] out_x_im;
		logic signed [VALUE_WIDTH-1:0] out_y_re;
		logic signed [VALUE_WIDTH-1:0] out_y_im;
		logic signed [VALUE_WIDTH-1:0] out_z_re;
		logic signed [VALUE_WIDTH-1:0] out_z_im;
		logic                          fault;
	} dkm_res_t;

	// One kernel store entry: three diagonal and three off-diagonal terms
	typedef struct packed {
		logic signed [VALUE_WIDTH-1:0] xx;
		logic signed [VALUE_WIDTH-1:0] yy;
		logic signed [VALUE_WIDTH-1:0] zz;
		logic signed [VALUE_WIDTH-1:0] xy;
		logic signed [VALUE_WIDTH-1:0] xz;
		logic signed [VALUE_WIDTH-1:0] yz;
	} dkm_kernel_t;

	typedef struct packed {
		logic                 mode_three_d;
		logic [IDX_W-1:0]     half_y;
		logic [IDX_W-1:0]     half_z;
		logic [IDX_W-1:0]     row_stride;
		logic [PSTRIDE_W-1:0] plane_stride;
	} dkm_cfg_t;

	// Index stage result: store address, range check and fold signs
	typedef struct packed {
		logic [ADDR_SUM_W-1:0] addr;
		logic                  ok;
		logic                  odd_y;
		logic                  odd_z;
	} dkm_idx_t;

	typedef logic [VEC_WORDS-1:0][VALUE_WIDTH-1:0] dkm_vec_t;

endpackage

`default_nettype wire

[rtl/dkm_index.sv]
// ----------------------------------------------------------------------------
// dkm_index: fold and address stage
// Folds y (and z in 3D) about their half points on multiply, forms the kernel
// store address and checks x, y (and z in 3D) and the address against their ranges.
// ----------------------------------------------------------------------------
`default_nettype none

module dkm_index #(
	parameter int KERNEL_DEPTH = dkm_pkg::KERNEL_DEPTH_DEFAULT
) (
	input  dkm_pkg::dkm_cmd_t cmd,
	input  dkm_pkg::dkm_cfg_t cfg,
	output dkm_pkg::dkm_idx_t idx
);
	import dkm_pkg::*;

	logic [IDX_W:0]             two_hy;
	logic [IDX_W:0]             two_hz;
	logic                       y_above;
	logic                       z_above;
	logic                       is_load;
	logic                       ok_x;
	logic                       ok_range;
	logic [IDX_W-1:0]           y_fold;
	logic [IDX_W-1:0]           z_fold;
	logic [IDX_W-1:0]           y_sel;
	logic [IDX_W-1:0]           z_sel;
	logic [2*IDX_W-1:0]         y_off;
	logic [IDX_W+PSTRIDE_W-1:0] z_off;
	logic [ADDR_SUM_W-1:0]      addr_sum;

	always_comb begin
		two_hy  = {cfg.half_y, 1'b0};
		two_hz  = {cfg.half_z, 1'b0};
		y_above = cmd.y_index > cfg.half_y;
		z_above = cmd.z_index > cfg.half_z;
		y_fold  = IDX_W'(two_hy - {1'b0, cmd.y_index});
		z_fold  = IDX_W'(two_hz - {1'b0, cmd.z_index});
		is_load = cmd.opcode == OP_LOAD;
		ok_x    = cmd.x_index < cfg.row_stride;

		if (is_load) begin
			// loads address the half spectrum directly, no fold
			ok_range = ok_x && !y_above && (!cfg.mode_three_d || !z_above);
			y_sel    = cmd.y_index;
			z_sel    = cfg.mode_three_d ? cmd.z_index : '0;
		end else begin
			ok_range = ok_x && ({1'b0, cmd.y_index} < two_hy)
				&& (!cfg.mode_three_d || ({1'b0, cmd.z_index} < two_hz));
			y_sel    = y_above ? y_fold : cmd.y_index;
			z_sel    = cfg.mode_three_d ? (z_above ? z_fold : cmd.z_index) : '0;
		end

		y_off    = y_sel * cfg.row_stride;
		z_off    = z_sel * cfg.plane_stride;
		addr_sum = ADDR_SUM_W'(cmd.x_index) + ADDR_SUM_W'(y_off) + ADDR_SUM_W'(z_off);

		idx.addr  = addr_sum;
		idx.ok    = ok_range && (addr_sum < ADDR_SUM_W'(KERNEL_DEPTH));
		idx.odd_y = !is_load && y_above;
		idx.odd_z = !is_load && cfg.mode_three_d && z_above;
	end

endmodule

`default_nettype wire

[rtl/dkm_kernel_ram.sv]
// ----------------------------------------------------------------------------
// dkm_kernel_ram: kernel store
// Single-port synchronous memory, one kernel entry per word, registered
// read data. Contents are not cleared by reset.
// ----------------------------------------------------------------------------
`default_nettype none

module dkm_kernel_ram #(
	parameter int DEPTH = dkm_pkg::KERNEL_DEPTH_DEFAULT,
	parameter int WIDTH = $bits(dkm_pkg::dkm_kernel_t),
	parameter int AW    = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             wr_en,
	input  logic             rd_en,
	input  logic [AW-1:0]    addr,
	input  logic [WIDTH-1:0] wr_data,
	output logic [WIDTH-1:0] rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[addr];
		end
	end

endmodule

`default_nettype wire

[rtl/dkm_tensor_mac.sv]
// ----------------------------------------------------------------------------
// dkm_tensor_mac: symmetric tensor times complex vector
// Applies the fold signs to the kernel, forms the eighteen products,
// sums each row with the rounding half, then rounds and saturates.
// ----------------------------------------------------------------------------
`default_nettype none

module dkm_tensor_mac (
	input  logic                clk,
	input  logic                en_s3,
	input  logic                en_s4,
	input  logic                mode_three_d,
	input  logic                odd_y,
	input  logic                odd_z,
	input  dkm_pkg::dkm_kernel_t kern,
	input  dkm_pkg::dkm_vec_t    vec,
	output dkm_pkg::dkm_vec_t    result
);
	import dkm_pkg::*;

	localparam int KW     = VALUE_WIDTH + 1;
	localparam int PROD_W = VALUE_WIDTH + KW;
	localparam int SUM_W  = PROD_W + 2;
	localparam logic signed [SUM_W-1:0] ROUND_HALF = SUM_W'(1) <<< (FRACTION_BITS - 1);
	localparam logic signed [SUM_W-1:0] SAT_MAX = (SUM_W'(1) <<< (VALUE_WIDTH - 1)) - SUM_W'(1);
	localparam logic signed [SUM_W-1:0] SAT_MIN = -(SUM_W'(1) <<< (VALUE_WIDTH - 1));

	logic signed [KW-1:0]          kxy;
	logic signed [KW-1:0]          kxz;
	logic signed [KW-1:0]          kyz;
	logic signed [KW-1:0]          mat [3][3];
	logic signed [VALUE_WIDTH-1:0] vv [3][2];
	logic signed [PROD_W-1:0]      prod_s3 [3][2][3];
	logic signed [SUM_W-1:0]       sum_s4 [3][2];
	logic signed [SUM_W-1:0]       shifted [3][2];

	// Flip off-diagonal signs for folded indices; 2D drops xz and yz
	always_comb begin
		kxy = odd_y ? -KW'($signed(kern.xy)) : KW'($signed(kern.xy));
		kxz = !mode_three_d ? '0
			: (odd_z ? -KW'($signed(kern.xz)) : KW'($signed(kern.xz)));
		kyz = !mode_three_d ? '0
			: ((odd_y ^ odd_z) ? -KW'($signed(kern.yz)) : KW'($signed(kern.yz)));

		mat[0][0] = KW'($signed(kern.xx));
		mat[0][1] = kxy;
		mat[0][2] = kxz;
		mat[1][0] = kxy;
		mat[1][1] = KW'($signed(kern.yy));
		mat[1][2] = kyz;
		mat[2][0] = kxz;
		mat[2][1] = kyz;
		mat[2][2] = KW'($signed(kern.zz));

		for (int c = 0; c < 3; c++) begin
			for (int p = 0; p < 2; p++) begin
				vv[c][p] = $signed(vec[2*c+p]);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en_s3) begin
			for (int r = 0; r < 3; r++) begin
				for (int p = 0; p < 2; p++) begin
					for (int c = 0; c < 3; c++) begin
						prod_s3[r][p][c] <= PROD_W'(mat[r][c]) * PROD_W'(vv[c][p]);
					end
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en_s4) begin
			for (int r = 0; r < 3; r++) begin
				for (int p = 0; p < 2; p++) begin
					sum_s4[r][p] <= SUM_W'(prod_s3[r][p][0]) + SUM_W'(prod_s3[r][p][1])
						+ SUM_W'(prod_s3[r][p][2]) + ROUND_HALF;
				end
			end
		end
	end

	// Drop the fraction (half already added) and clamp to the word range
	always_comb begin
		for (int r = 0; r < 3; r++) begin
			for (int p = 0; p < 2; p++) begin
				shifted[r][p] = sum_s4[r][p] >>> FRACTION_BITS;
				if (shifted[r][p] > SAT_MAX) begin
					result[2*r+p] = SAT_MAX[VALUE_WIDTH-1:0];
				end else if (shifted[r][p] < SAT_MIN) begin
					result[2*r+p] = SAT_MIN[VALUE_WIDTH-1:0];
				end else begin
					result[2*r+p] = shifted[r][p][VALUE_WIDTH-1:0];
				end
			end
		end
	end

endmodule

`default_nettype wire

[rtl/demag_kernel_multiply.sv]
// Path: a multiply word, or a load that faults, passes through s1, s2, s3 and s4
//   into the result register; an in-range load returns no word.
// Throughput: one word per cycle while the output is not stalled, set by the single
//   kernel store port, which serves one load write or one multiply read each cycle.
// Reset: clears all valid flags and the configuration registers to their reset
//   values; the kernel store keeps its contents and needs no clearing pass.
// ----------------------------------------------------------------------------
// demag_kernel_multiply: spectral demag kernel multiply
// Pipeline: s1 index fold and address, s2 kernel store read (or load write),
// s3 products, s4 row sums, then the result register. Each stage advances
// when it is empty or the stage after it advances, so bubbles close up and
// new words are taken while a finished result waits on the output.
// ----------------------------------------------------------------------------
`default_nettype none

module demag_kernel_multiply #(
	parameter int KERNEL_DEPTH = dkm_pkg::KERNEL_DEPTH_DEFAULT
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_wr_en,
	input  logic [dkm_pkg::CFG_INDEX_W-1:0]      cfg_index,
	input  logic [dkm_pkg::CFG_DATA_W-1:0]       cfg_data,
	input  logic                                 cmd_valid,
	output logic                                 cmd_stall,
	input  dkm_pkg::dkm_cmd_t                    cmd_word,
	output logic                                 res_valid,
	input  logic                                 res_stall,
	output dkm_pkg::dkm_res_t                    res_word
);
	import dkm_pkg::*;

	localparam int AW = $clog2(KERNEL_DEPTH);

	// configuration registers
	logic                 mode_three_d_q;
	logic [IDX_W-1:0]     half_y_q;
	logic [IDX_W-1:0]     half_z_q;
	logic [IDX_W-1:0]     row_stride_q;
	logic [PSTRIDE_W-1:0] plane_stride_q;
	dkm_cfg_t             cfg;

	// stage enables
	logic en_s1;
	logic en_s2;
	logic en_s3;
	logic en_s4;
	logic en_out;

	dkm_idx_t    idx;
	logic        v_s1;
	dkm_cmd_t    cmd_s1;
	dkm_idx_t    idx_s1;
	logic        produces_s1;
	logic        ram_wr_en;
	dkm_kernel_t ram_wr_data;
	dkm_kernel_t kern_s2;

	logic     v_s2;
	logic     fault_s2;
	logic     odd_y_s2;
	logic     odd_z_s2;
	dkm_vec_t vec_s2;

	logic     v_s3;
	logic     fault_s3;
	logic     v_s4;
	logic     fault_s4;
	dkm_vec_t result;

	logic     res_valid_q;
	dkm_res_t res_q;

	// Config: the user must write it only while the pipeline is empty; the block itself does not enforce this
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_three_d_q <= 1'b0;
			half_y_q       <= IDX_W'(1);
			half_z_q       <= IDX_W'(1);
			row_stride_q   <= IDX_W'(1);
			plane_stride_q <= PSTRIDE_W'(1);
		end else if (cfg_wr_en) begin
			case (cfg_index)
				REG_MODE_THREE_D: mode_three_d_q <= cfg_data[0];
				REG_HALF_Y:       half_y_q       <= cfg_data[IDX_W-1:0];
				REG_HALF_Z:       half_z_q       <= cfg_data[IDX_W-1:0];
				REG_ROW_STRIDE:   row_stride_q   <= cfg_data[IDX_W-1:0];
				REG_PLANE_STRIDE: plane_stride_q <= cfg_data[PSTRIDE_W-1:0];
				default: begin
				end
			endcase
		end
	end

	assign cfg.mode_three_d = mode_three_d_q;
	assign cfg.half_y       = half_y_q;
	assign cfg.half_z       = half_z_q;
	assign cfg.row_stride   = row_stride_q;
	assign cfg.plane_stride = plane_stride_q;

	// Advance a stage when it is empty or its successor advances
	assign en_out = !res_valid_q || !res_stall;
	assign en_s4  = !v_s4 || en_out;
	assign en_s3  = !v_s3 || en_s4;
	assign en_s2  = !v_s2 || en_s3;
	assign en_s1  = !v_s1 || en_s2;

	assign cmd_stall = !en_s1;

	dkm_index #(
		.KERNEL_DEPTH(KERNEL_DEPTH)
	) u_index (
		.cmd(cmd_word),
		.cfg(cfg),
		.idx(idx)
	);

	// s1: register the word with its folded address
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en_s1) begin
			v_s1 <= cmd_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s1 && cmd_valid) begin
			cmd_s1 <= cmd_word;
			idx_s1 <= idx;
		end
	end

	// An in-range load stores its entry and is dropped here; every other word
	// carries on. Read and write both issue from s1 in word order, so a
	// multiply behind a load always sees the new entry.
	assign produces_s1 = (cmd_s1.opcode == OP_MULTIPLY) || !idx_s1.ok;
	assign ram_wr_en   = v_s1 && en_s2 && (cmd_s1.opcode == OP_LOAD) && idx_s1.ok;

	assign ram_wr_data.xx = cmd_s1.word_a;
	assign ram_wr_data.yy = cmd_s1.word_b;
	assign ram_wr_data.zz = cmd_s1.word_c;
	assign ram_wr_data.xy = cmd_s1.word_d;
	assign ram_wr_data.xz = cmd_s1.word_e;
	assign ram_wr_data.yz = cmd_s1.word_f;

	dkm_kernel_ram #(
		.DEPTH(KERNEL_DEPTH),
		.WIDTH($bits(dkm_kernel_t)),
		.AW(AW)
	) u_kernel_ram (
		.clk(clk),
		.wr_en(ram_wr_en),
		.rd_en(en_s2),
		.addr(idx_s1.addr[AW-1:0]),
		.wr_data(ram_wr_data),
		.rd_data(kern_s2)
	);

	// s2: kernel entry arrives from the store alongside the vector
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (en_s2) begin
			v_s2 <= v_s1 && produces_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s2) begin
			fault_s2 <= !idx_s1.ok;
			odd_y_s2 <= idx_s1.odd_y;
			odd_z_s2 <= idx_s1.odd_z;
			vec_s2   <= {cmd_s1.word_f, cmd_s1.word_e, cmd_s1.word_d,
				cmd_s1.word_c, cmd_s1.word_b, cmd_s1.word_a};
		end
	end

	dkm_tensor_mac u_tensor_mac (
		.clk(clk),
		.en_s3(en_s3),
		.en_s4(en_s4),
		.mode_three_d(mode_three_d_q),
		.odd_y(odd_y_s2),
		.odd_z(odd_z_s2),
		.kern(kern_s2),
		.vec(vec_s2),
		.result(result)
	);

	// s3 and s4: track valid and fault beside the arithmetic
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			if (en_s3) begin
				v_s3 <= v_s2;
			end
			if (en_s4) begin
				v_s4 <= v_s3;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en_s3) begin
			fault_s3 <= fault_s2;
		end
		if (en_s4) begin
			fault_s4 <= fault_s3;
		end
	end

	// Result register: hold while stalled, zero the product on a fault
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (en_out) begin
			res_valid_q <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (en_out && v_s4) begin
			res_q.fault <= fault_s4;
			if (fault_s4) begin
				res_q.out_x_re <= '0;
				res_q.out_x_im <= '0;
				res_q.out_y_re <= '0;
				res_q.out_y_im <= '0;
				res_q.out_z_re <= '0;
				res_q.out_z_im <= '0;
			end else begin
				res_q.out_x_re <= result[0];
				res_q.out_x_im <= result[1];
				res_q.out_y_re <= result[2];
				res_q.out_y_im <= result[3];
				res_q.out_z_re <= result[4];
				res_q.out_z_im <= result[5];
			end
		end
	end

	assign res_valid = res_valid_q;
	assign res_word  = res_q;

endmodule

`default_nettype wire

[rtl/dkm_checker.sv]
// ----------------------------------------------------------------------------
// dkm_checker: port-level checks for demag_kernel_multiply
// Watches both channels and flags result words that break the block's
// timing or fault rules, and input stalls while the output can drain.
// ----------------------------------------------------------------------------
`default_nettype none

module dkm_checker (
	input logic              clk,
	input logic              arst_n,
	input logic              cmd_valid,
	input logic              cmd_stall,
	input dkm_pkg::dkm_cmd_t cmd_word,
	input logic              res_valid,
	input logic              res_stall,
	input dkm_pkg::dkm_res_t res_word
);
	import dkm_pkg::*;

	// Hold a stalled result word
	assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_stall |=> res_valid && $stable(res_word))
	else $error("result word changed while stalled");

	// A faulting word carries an all-zero product
	assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_word.fault |-> res_word.out_x_re == '0 && res_word.out_x_im == '0
			&& res_word.out_y_re == '0 && res_word.out_y_im == '0
			&& res_word.out_z_re == '0 && res_word.out_z_im == '0)
	else $error("fault result with nonzero product");

	// With the output draining, an accepted multiply must come out on the result port
	assert property (@(posedge clk) disable iff (!arst_n)
		cmd_valid && !cmd_stall && cmd_word.opcode == OP_MULTIPLY
			##1 !res_stall ##1 !res_stall ##1 !res_stall ##1 !res_stall |=> res_valid)
	else $error("multiply result late or lost");

	// Input backpressure only when the whole pipeline is full behind a stall
	assert property (@(posedge clk) disable iff (!arst_n)
		cmd_stall |-> res_valid && res_stall)
	else $error("input stalled while output can drain");

endmodule

bind demag_kernel_multiply dkm_checker u_dkm_checker (
	.clk(clk),
	.arst_n(arst_n),
	.cmd_valid(cmd_valid),
	.cmd_stall(cmd_stall),
	.cmd_word(cmd_word),
	.res_valid(res_valid),
	.res_stall(res_stall),
	.res_word(res_word)
);

`default_nettype wire

[bench/dkm_product_checker.sv]
// ----------------------------------------------------------------------------
// dkm_product_checker: tensor product predictor and result comparison
// Mirrors the register writes and kernel loads seen on the ports, folds the
// multiply indices, forms the saturated Q16.16 products and compares every
// result word, field by field, against the oldest outstanding prediction.
// ----------------------------------------------------------------------------
`default_nettype none

module dkm_product_checker (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_wr_en,
	input  logic [dkm_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  logic [dkm_pkg::CFG_DATA_W-1:0]  cfg_data,
	input  logic                            cmd_valid,
	input  logic                            cmd_stall,
	input  dkm_pkg::dkm_cmd_t               cmd_word,
	input  logic                            res_valid,
	input  logic                            res_stall,
	input  dkm_pkg::dkm_res_t               res_word,
	output int                              mismatches,
	output int                              outstanding,
	output int                              results_seen,
	output int                              faults_seen
);
	import dkm_pkg::*;

	localparam int STORE_DEPTH = KERNEL_DEPTH_DEFAULT;
	localparam int WIDE_W      = 2 * VALUE_WIDTH + 4;
	localparam longint SAT_HI  = (longint'(1) <<< (VALUE_WIDTH - 1)) - 1;
	localparam longint SAT_LO  = -(longint'(1) <<< (VALUE_WIDTH - 1));

	dkm_cfg_t    regs;
	dkm_kernel_t kernel_store [STORE_DEPTH];
	dkm_res_t    product_q [$];
	int          miss_total  = 0;
	int          seen_total  = 0;
	int          fault_total = 0;

	initial begin
		mismatches   = 0;
		outstanding  = 0;
		results_seen = 0;
		faults_seen  = 0;
	end

	// Exact three-term sum, round half up, saturate
	function automatic logic signed [VALUE_WIDTH-1:0] mac3(
		input logic signed [VALUE_WIDTH:0]   k0,
		input logic signed [VALUE_WIDTH-1:0] v0,
		input logic signed [VALUE_WIDTH:0]   k1,
		input logic signed [VALUE_WIDTH-1:0] v1,
		input logic signed [VALUE_WIDTH:0]   k2,
		input logic signed [VALUE_WIDTH-1:0] v2
	);
		logic signed [WIDE_W-1:0] acc;
		acc = k0 * v0 + k1 * v1 + k2 * v2 + (1 <<< (FRACTION_BITS - 1));
		acc = acc >>> FRACTION_BITS;
		if (acc > SAT_HI)
			return SAT_HI[VALUE_WIDTH-1:0];
		if (acc < SAT_LO)
			return SAT_LO[VALUE_WIDTH-1:0];
		return acc[VALUE_WIDTH-1:0];
	endfunction

	function automatic void predict_product(input dkm_cmd_t c);
		int x, y, z, yf, zf, slot, hy, hz, rs, ps;
		bit ok, odd_y, odd_z, three_d;
		dkm_kernel_t k;
		logic signed [VALUE_WIDTH:0] kxx, kyy, kzz, kxy, kxz, kyz;
		dkm_res_t r;
		x = c.x_index;
		y = c.y_index;
		z = c.z_index;
		hy = regs.half_y;
		hz = regs.half_z;
		rs = regs.row_stride;
		ps = regs.plane_stride;
		three_d = regs.mode_three_d;
		r = '0;
		if (c.opcode == OP_LOAD) begin
			ok = x < rs && y <= hy && (!three_d || z <= hz);
			slot = x + y * rs + (three_d ? z * ps : 0);
			if (ok && slot < STORE_DEPTH) begin
				kernel_store[slot] = {c.word_a, c.word_b, c.word_c, c.word_d, c.word_e, c.word_f};
				return;
			end
			r.fault = 1'b1;
			product_q.push_back(r);
			return;
		end
		// Multiply: fold the upper half back onto the stored half
		odd_y = y > hy;
		yf = odd_y ? 2 * hy - y : y;
		ok = x < rs && y < 2 * hy;
		odd_z = 1'b0;
		zf = 0;
		if (three_d) begin
			ok = ok && z < 2 * hz;
			odd_z = z > hz;
			zf = odd_z ? 2 * hz - z : z;
		end
		slot = x + yf * rs + zf * ps;
		if (!ok || slot >= STORE_DEPTH) begin
			r.fault = 1'b1;
			product_q.push_back(r);
			return;
		end
		k = kernel_store[slot];
		kxx = k.xx;
		kyy = k.yy;
		kzz = k.zz;
		kxy = odd_y ? -k.xy : k.xy;
		kxz = odd_z ? -k.xz : k.xz;
		kyz = (odd_y != odd_z) ? -k.yz : k.yz;
		if (!three_d) begin
			kxz = '0;
			kyz = '0;
		end
		r.out_x_re = mac3(kxx, c.word_a, kxy, c.word_c, kxz, c.word_e);
		r.out_x_im = mac3(kxx, c.word_b, kxy, c.word_d, kxz, c.word_f);
		r.out_y_re = mac3(kxy, c.word_a, kyy, c.word_c, kyz, c.word_e);
		r.out_y_im = mac3(kxy, c.word_b, kyy, c.word_d, kyz, c.word_f);
		r.out_z_re = mac3(kxz, c.word_a, kyz, c.word_c, kzz, c.word_e);
		r.out_z_im = mac3(kxz, c.word_b, kyz, c.word_d, kzz, c.word_f);
		product_q.push_back(r);
	endfunction

	task automatic check_field(input string name, input logic signed [VALUE_WIDTH-1:0] want,
		input logic signed [VALUE_WIDTH-1:0] got);
		if (got !== want) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			miss_total++;
		end
	endtask

	task automatic compare_result(input dkm_res_t got);
		dkm_res_t want;
		if (product_q.size() == 0) begin
			$error("result word arrived with no product outstanding");
			miss_total++;
			return;
		end
		want = product_q.pop_front();
		seen_total++;
		if (want.fault)
			fault_total++;
		check_field("out_x_re", want.out_x_re, got.out_x_re);
		check_field("out_x_im", want.out_x_im, got.out_x_im);
		check_field("out_y_re", want.out_y_re, got.out_y_re);
		check_field("out_y_im", want.out_y_im, got.out_y_im);
		check_field("out_z_re", want.out_z_re, got.out_z_re);
		check_field("out_z_im", want.out_z_im, got.out_z_im);
		check_field("fault", want.fault, got.fault);
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs = '{mode_three_d: 1'b0, half_y: 7'd1, half_z: 7'd1,
				row_stride: 7'd1, plane_stride: 13'd1};
			product_q.delete();
		end else begin
			// a result can never belong to a word taken at the same edge
			if (res_valid && !res_stall)
				compare_result(res_word);
			if (cfg_wr_en) begin
				case (cfg_index)
					REG_MODE_THREE_D: regs.mode_three_d = cfg_data[0];
					REG_HALF_Y:       regs.half_y       = cfg_data[IDX_W-1:0];
					REG_HALF_Z:       regs.half_z       = cfg_data[IDX_W-1:0];
					REG_ROW_STRIDE:   regs.row_stride   = cfg_data[IDX_W-1:0];
					REG_PLANE_STRIDE: regs.plane_stride = cfg_data[PSTRIDE_W-1:0];
					default: ;
				endcase
			end
			if (cmd_valid && !cmd_stall)
				predict_product(cmd_word);
		end
		mismatches   <= miss_total;
		outstanding  <= product_q.size();
		results_seen <= seen_total;
		faults_seen  <= fault_total;
	end

endmodule

`default_nettype wire

[bench/tb_demag_kernel_multiply.sv]
// ----------------------------------------------------------------------------
// tb_demag_kernel_multiply: stimulus and verdict for the kernel multiply
// Drives kernel loads and vector multiplies through several register
// settings, 2D and 3D, with random gaps on both channels; a product checker
// beside the block predicts and compares every result word.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_demag_kernel_multiply;
	import dkm_pkg::*;

	localparam int STORE_DEPTH = KERNEL_DEPTH_DEFAULT;
	// cycles to let an in-range load (which returns nothing) clear the pipe
	localparam int PIPE_TAIL   = 8;

	localparam logic signed [VALUE_WIDTH-1:0] Q_MAX  = 32'sh7fffffff;
	localparam logic signed [VALUE_WIDTH-1:0] Q_MIN  = 32'sh80000000;
	localparam logic signed [VALUE_WIDTH-1:0] Q_ONE  = 32'sh00010000;
	localparam logic signed [VALUE_WIDTH-1:0] Q_HALF = 32'sh00008000;

	logic                   clk;
	logic                   arst_n    = 1'b0;
	logic                   cfg_wr_en = 1'b0;
	logic [CFG_INDEX_W-1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0]  cfg_data  = '0;
	logic                   cmd_valid = 1'b0;
	logic                   cmd_stall;
	dkm_cmd_t               cmd_word  = '0;
	logic                   res_valid;
	logic                   res_stall = 1'b0;
	dkm_res_t               res_word;

	int mismatches, outstanding, results_seen, faults_seen;

	// Register settings as the stimulus sees them, kept to aim the indices
	bit cur_three_d      = 1'b0;
	int cur_half_y       = 1;
	int cur_half_z       = 1;
	int cur_row_stride   = 1;
	int cur_plane_stride = 1;

	// Store entries written so far: a multiply must never read an entry never written
	bit loaded [STORE_DEPTH];

	// Set during the stretch where neither side idles
	bit steady      = 1'b0;
	int words_sent  = 0;
	int phases_run  = 0;

	demag_kernel_multiply dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cmd_valid (cmd_valid),
		.cmd_stall (cmd_stall),
		.cmd_word  (cmd_word),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.res_word  (res_word)
	);

	dkm_product_checker product_check (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_wr_en    (cfg_wr_en),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.cmd_valid    (cmd_valid),
		.cmd_stall    (cmd_stall),
		.cmd_word     (cmd_word),
		.res_valid    (res_valid),
		.res_stall    (res_stall),
		.res_word     (res_word),
		.mismatches   (mismatches),
		.outstanding  (outstanding),
		.results_seen (results_seen),
		.faults_seen  (faults_seen)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// Hard stop in case the block hangs on either channel
	initial begin
		#2_000_000;
		$display("demag_kernel_multiply: mismatch");
		$finish;
	end

	// Result side: stall about a third of the cycles, except in the steady stretch
	always @(negedge clk) begin
		res_stall <= !steady && ($urandom_range(0, 99) < 33);
	end

	// Store slot an item touches under the current settings, -1 when it faults.
	// For a multiply the folded y and z come back so the entry can be preloaded.
	function automatic int slot_of(input bit is_load, input int x, input int y, input int z,
		output int yf, output int zf);
		bit ok;
		int slot;
		yf = y;
		zf = cur_three_d ? z : 0;
		if (is_load) begin
			ok = x < cur_row_stride && y <= cur_half_y && (!cur_three_d || z <= cur_half_z);
		end else begin
			ok = x < cur_row_stride && y < 2 * cur_half_y
				&& (!cur_three_d || z < 2 * cur_half_z);
			if (y > cur_half_y)
				yf = 2 * cur_half_y - y;
			if (cur_three_d && z > cur_half_z)
				zf = 2 * cur_half_z - z;
		end
		slot = x + yf * cur_row_stride + zf * cur_plane_stride;
		return (ok && slot < STORE_DEPTH) ? slot : -1;
	endfunction

	// Mix of full-range noise, small Q16.16 values and the rails
	function automatic logic signed [VALUE_WIDTH-1:0] rand_word();
		case ($urandom_range(0, 4))
			0: return $urandom;
			1: return $urandom_range(0, 1 << 20) - (1 << 19);
			2: begin
				case ($urandom_range(0, 3))
					0: return Q_MAX;
					1: return Q_MIN;
					2: return '0;
					default: return -1;
				endcase
			end
			default: return $urandom_range(0, 8 << 16) - (4 << 16);
		endcase
	endfunction

	function automatic dkm_cmd_t fixed_cmd(input logic op, input int x, input int y, input int z,
		input logic signed [VALUE_WIDTH-1:0] a, input logic signed [VALUE_WIDTH-1:0] b,
		input logic signed [VALUE_WIDTH-1:0] c, input logic signed [VALUE_WIDTH-1:0] d,
		input logic signed [VALUE_WIDTH-1:0] e, input logic signed [VALUE_WIDTH-1:0] f);
		dkm_cmd_t w;
		w.opcode  = op;
		w.x_index = x[IDX_W-1:0];
		w.y_index = y[IDX_W-1:0];
		w.z_index = z[IDX_W-1:0];
		w.word_a  = a;
		w.word_b  = b;
		w.word_c  = c;
		w.word_d  = d;
		w.word_e  = e;
		w.word_f  = f;
		return w;
	endfunction

	function automatic dkm_cmd_t random_cmd(input logic op, input int x, input int y,
		input int z);
		return fixed_cmd(op, x, y, z, rand_word(), rand_word(), rand_word(),
			rand_word(), rand_word(), rand_word());
	endfunction

	// Present one word at the falling edge, with random idle cycles ahead of it,
	// and hold it until a rising edge takes it
	task automatic issue_word(input dkm_cmd_t w);
		int slot, yf, zf;
		@(negedge clk);
		while (!steady && $urandom_range(0, 99) < 33) begin
			cmd_valid <= 1'b0;
			@(negedge clk);
		end
		cmd_valid <= 1'b1;
		cmd_word  <= w;
		@(posedge clk);
		while (cmd_stall)
			@(posedge clk);
		words_sent++;
		if (w.opcode == OP_LOAD) begin
			slot = slot_of(1'b1, w.x_index, w.y_index, w.z_index, yf, zf);
			if (slot >= 0)
				loaded[slot] = 1'b1;
		end
	endtask

	task automatic send_load(input int x, input int y, input int z);
		issue_word(random_cmd(OP_LOAD, x, y, z));
	endtask

	// Multiply; an entry that was never written gets a load at the folded
	// indices first, so the pair forms a well-formed load-then-use sequence
	task automatic send_multiply(input int x, input int y, input int z);
		int slot, yf, zf;
		slot = slot_of(1'b0, x, y, z, yf, zf);
		if (slot >= 0 && !loaded[slot])
			send_load(x, yf, cur_three_d ? zf : $urandom_range(0, 127));
		issue_word(random_cmd(OP_MULTIPLY, x, y, z));
	endtask

	// Drop valid and wait for every product, then let a trailing load drain
	task automatic drain();
		@(negedge clk);
		cmd_valid <= 1'b0;
		while (outstanding != 0)
			@(posedge clk);
		repeat (PIPE_TAIL) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input int value);
		@(negedge clk);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value[CFG_DATA_W-1:0];
	endtask

	// Registers change only with the pipe empty
	task automatic apply_config(input bit three_d, input int half_y, input int half_z,
		input int row_stride, input int plane_stride);
		drain();
		write_reg(REG_MODE_THREE_D, three_d);
		write_reg(REG_HALF_Y, half_y);
		write_reg(REG_HALF_Z, half_z);
		write_reg(REG_ROW_STRIDE, row_stride);
		write_reg(REG_PLANE_STRIDE, plane_stride);
		@(negedge clk);
		cfg_wr_en <= 1'b0;
		cur_three_d      = three_d;
		cur_half_y       = half_y;
		cur_half_z       = half_z;
		cur_row_stride   = row_stride;
		cur_plane_stride = plane_stride;
		phases_run++;
	endtask

	// Mostly in-range multiplies and loads, the rest any 7-bit indices
	task automatic random_phase(input int count);
		int pick;
		repeat (count) begin
			pick = $urandom_range(0, 99);
			if (pick < 55)
				send_multiply($urandom_range(0, cur_row_stride - 1),
					$urandom_range(0, 2 * cur_half_y - 1),
					cur_three_d ? $urandom_range(0, 2 * cur_half_z - 1) : $urandom_range(0, 127));
			else if (pick < 80)
				send_load($urandom_range(0, cur_row_stride - 1), $urandom_range(0, cur_half_y),
					cur_three_d ? $urandom_range(0, cur_half_z) : $urandom_range(0, 127));
			else if (pick < 90)
				send_multiply($urandom_range(0, 127), $urandom_range(0, 127),
					$urandom_range(0, 127));
			else
				send_load($urandom_range(0, 127), $urandom_range(0, 127),
					$urandom_range(0, 127));
		end
	endtask

	initial begin
		int hy, rs;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Reset settings: 2D, half_y 1, one entry per row
		issue_word(fixed_cmd(OP_LOAD, 0, 0, 0, Q_MAX, Q_MIN, Q_ONE, Q_MIN, Q_MAX, -Q_ONE));
		issue_word(fixed_cmd(OP_LOAD, 0, 1, 5, 1, -1, Q_HALF, 3 * Q_ONE, Q_ONE, Q_ONE));
		// x at the row stride, y past the half point: both loads fault
		issue_word(fixed_cmd(OP_LOAD, 1, 0, 0, Q_ONE, Q_ONE, Q_ONE, Q_ONE, Q_ONE, Q_ONE));
		issue_word(fixed_cmd(OP_LOAD, 0, 2, 0, Q_ONE, Q_ONE, Q_ONE, Q_ONE, Q_ONE, Q_ONE));
		// saturate high and low
		issue_word(fixed_cmd(OP_MULTIPLY, 0, 0, 0, Q_MAX, Q_MAX, Q_MAX, Q_MAX, Q_MAX, Q_MAX));
		issue_word(fixed_cmd(OP_MULTIPLY, 0, 0, 0, Q_MIN, Q_MIN, Q_MIN, Q_MIN, Q_MIN, Q_MIN));
		// y equal to the half point is not folded; half-LSB rounding on xx
		issue_word(fixed_cmd(OP_MULTIPLY, 0, 1, 0, Q_HALF, -Q_HALF, 0, 0, Q_ONE, -Q_ONE));
		// y at twice the half point, x at the row stride, all indices at top
		issue_word(fixed_cmd(OP_MULTIPLY, 0, 2, 0, Q_ONE, Q_ONE, Q_ONE, Q_ONE, Q_ONE, Q_ONE));
		issue_word(fixed_cmd(OP_MULTIPLY, 1, 0, 0, Q_ONE, Q_ONE, Q_ONE, Q_ONE, Q_ONE, Q_ONE));
		issue_word(fixed_cmd(OP_MULTIPLY, 127, 127, 127, Q_MAX, Q_MIN, Q_MAX, Q_MIN, 1, -1));

		// Small 3D grid: every fold combination and the range faults
		apply_config(1'b1, 2, 2, 3, 9);
		issue_word(fixed_cmd(OP_LOAD, 1, 1, 1, 1, -1, Q_HALF, Q_MIN, Q_MAX, 0));
		send_load(2, 2, 2);
		send_load(0, 0, 0);
		send_load(0, 0, 3);
		send_load(3, 0, 0);
		issue_word(fixed_cmd(OP_MULTIPLY, 1, 1, 1, Q_HALF, -Q_HALF, 0, 0, 0, 0));
		send_multiply(2, 2, 2);
		send_multiply(1, 3, 1);
		send_multiply(1, 1, 3);
		send_multiply(1, 3, 3);
		send_multiply(0, 0, 4);
		send_multiply(0, 4, 0);

		// Register extremes: largest grid, smallest grid, wide 2D
		apply_config(1'b1, 64, 64, 65, 4096);
		random_phase(50);
		apply_config(1'b1, 1, 1, 1, 1);
		random_phase(50);
		apply_config(1'b0, 64, 1, 65, 1);
		random_phase(50);

		// Back-to-back stretch with no idling on either side
		steady = 1'b1;
		apply_config(1'b0, 6, 3, 7, 49);
		random_phase(60);
		steady = 1'b0;

		// Random grids, mostly with consistent strides
		repeat (4) begin
			hy = $urandom_range(1, 10);
			rs = $urandom_range(1, 12);
			apply_config($urandom_range(0, 1), hy, $urandom_range(1, 10), rs,
				($urandom_range(0, 3) == 0) ? $urandom_range(1, 4096) : rs * (hy + 1));
			random_phase(45);
		end

		drain();
		$display("covered %0d command words over %0d register settings, 2D and 3D",
			words_sent, phases_run);
		$display("compared %0d product words, %0d of them range faults",
			results_seen, faults_seen);
		if (mismatches == 0 && outstanding == 0) begin
			$display("demag_kernel_multiply: match");
		end else begin
			$display("demag_kernel_multiply: mismatch");
		end
		$finish;
	end

endmodule

`default_nettype wire
